FILE: src/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants of the Cartesian domain split block.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int CNT_W   = 12;    // processor count, rank, grid sizes
	localparam int CELL_W  = 16;    // cell counts and offsets
	localparam int COST_W  = 29;    // cols*cells_z + rows*cells_y
	localparam int DIV_W   = 16;    // shared divider width
	localparam int MAX_PRIME = 4096; // trial divisors stay below this

	// register addresses (word index)
	localparam logic [1:0] REG_CPU_COUNT  = 2'd0;
	localparam logic [1:0] REG_CELLS_Y    = 2'd1;
	localparam logic [1:0] REG_CELLS_Z    = 2'd2;
	localparam logic [1:0] REG_PERIODIC_Z = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ERR,
		OP_FAC_INIT,
		OP_FAC_APPEND,
		OP_FAC_DIV,
		OP_FAC_WAIT,
		OP_COMB_INIT,
		OP_COMB_START,
		OP_COMB_MUL,
		OP_COST_MUL,
		OP_COST_CMP,
		OP_RANK_DIV,
		OP_RANK_WAIT,
		OP_Y_DIV,
		OP_Y_WAIT,
		OP_Z_DIV,
		OP_Z_WAIT,
		OP_SHARE_MUL,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic rank_bad;   // rank >= cpu_count
		logic fac_done;   // cofactor reached 1
		logic fac_stop;   // remaining cofactor becomes the last factor
		logic comb_done;  // all combinations tried
		logic mul_done;   // products of this combination complete
		logic div_done;   // divider result ready
	} dp_status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FAC,
		ST_FAC_WAIT,
		ST_COMB_INIT,
		ST_COMB_START,
		ST_COMB_MUL,
		ST_COST_MUL,
		ST_COST_CMP,
		ST_RANK_DIV,
		ST_RANK_WAIT,
		ST_Y_DIV,
		ST_Y_WAIT,
		ST_Z_DIV,
		ST_Z_WAIT,
		ST_SHARE_MUL,
		ST_FINISH,
		ST_OUT
	} ctrl_state_t;

endpackage
`default_nettype wire

FILE: src/cds_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cds_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cds_pkg::DIV_W-1:0]     dividend,
	input  wire logic [cds_pkg::DIV_W-1:0]     divisor,
	output logic      [cds_pkg::DIV_W-1:0]     quotient,
	output logic      [cds_pkg::DIV_W-1:0]     remainder,
	output logic                               done
);
	localparam int W  = cds_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    r_sh;
	logic [W:0]    r_sub;

	assign r_sh  = {rem_q, quo_q[W-1]};
	assign r_sub = r_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!r_sub[W]) begin
				rem_q <= r_sub[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= r_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule
`default_nettype wire

FILE: src/cds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_datapath
// Factor store, combination search, divider and result registers.
// ----------------------------------------------------------------------------
module cds_datapath #(
	parameter int MAX_FACTORS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cds_pkg::dp_cmd_t                cmd,
	output cds_pkg::dp_status_t                  status,
	input  wire logic [cds_pkg::CNT_W-1:0]       cpu_count,
	input  wire logic [cds_pkg::CELL_W-1:0]      cells_y,
	input  wire logic [cds_pkg::CELL_W-1:0]      cells_z,
	input  wire logic                            periodic_z,
	input  wire logic [cds_pkg::CNT_W-1:0]       rank,
	output logic      [cds_pkg::CNT_W-1:0]       grid_cols,
	output logic      [cds_pkg::CNT_W-1:0]       grid_rows,
	output logic      [cds_pkg::CNT_W-1:0]       col_index,
	output logic      [cds_pkg::CNT_W-1:0]       row_index,
	output logic      [cds_pkg::CELL_W-1:0]      local_y_cells,
	output logic      [cds_pkg::CELL_W-1:0]      local_z_cells,
	output logic      [cds_pkg::CELL_W-1:0]      y_offset,
	output logic      [cds_pkg::CELL_W-1:0]      z_offset,
	output logic      [3:0]                      boundary_flags,
	output logic                                 rank_error
);
	localparam int NW  = cds_pkg::CNT_W;
	localparam int LW  = cds_pkg::CELL_W;
	localparam int DW  = cds_pkg::DIV_W;
	localparam int JW  = $clog2(MAX_FACTORS);
	localparam int FCW = $clog2(MAX_FACTORS + 1);
	localparam int CBW = MAX_FACTORS + 1;

	logic [NW-1:0]  rank_q;
	logic [NW-1:0]  n_q;
	logic [NW-1:0]  d_q;
	logic [NW-1:0]  fac_q [MAX_FACTORS];
	logic [FCW-1:0] nf_q;
	logic [CBW-1:0] comb_q;
	logic [FCW-1:0] j_q;
	logic [NW-1:0]  cols_q;
	logic [NW-1:0]  rows_q;
	logic [NW+LW-1:0] pc_s1;
	logic [NW+LW-1:0] pr_s1;
	logic [cds_pkg::COST_W-1:0] cost;
	logic [cds_pkg::COST_W-1:0] best_cost_q;
	logic           have_q;
	logic [NW-1:0]  best_cols_q;
	logic [NW-1:0]  best_rows_q;
	logic [NW-1:0]  col_q;
	logic [NW-1:0]  row_q;
	logic [LW-1:0]  qy_q, ry_q, qz_q, rz_q;
	logic           ylt_q, zlt_q;
	logic [LW-1:0]  ly_s1, lz_s1;
	logic [LW-1:0]  my_s1, mz_s1;
	logic           ylt, zlt;
	logic [LW-1:0]  ly_n, lz_n;
	logic [NW+LW-1:0] my_full, mz_full;
	logic [2*NW-1:0] dd;
	logic [2*NW-1:0] fprod;
	logic [NW-1:0]  fsel;
	logic           div_start;
	logic [DW-1:0]  div_a, div_b, div_q, div_r;
	logic           div_done;

	cds_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.quotient  (div_q),
		.remainder (div_r),
		.done      (div_done)
	);

	always_comb begin
		div_start = 1'b0;
		div_a     = {{(DW-NW){1'b0}}, n_q};
		div_b     = {{(DW-NW){1'b0}}, d_q};
		case (cmd.op)
			cds_pkg::OP_FAC_DIV: begin
				div_start = 1'b1;
			end
			cds_pkg::OP_RANK_DIV: begin
				div_start = 1'b1;
				div_a     = {{(DW-NW){1'b0}}, rank_q};
				div_b     = {{(DW-NW){1'b0}}, best_cols_q};
			end
			cds_pkg::OP_Y_DIV: begin
				div_start = 1'b1;
				div_a     = cells_y;
				div_b     = {{(DW-NW){1'b0}}, best_cols_q};
			end
			cds_pkg::OP_Z_DIV: begin
				div_start = 1'b1;
				div_a     = cells_z;
				div_b     = {{(DW-NW){1'b0}}, best_rows_q};
			end
			default: begin
			end
		endcase
	end

	assign dd       = d_q * d_q;
	assign fsel     = fac_q[j_q[JW-1:0]];
	assign fprod    = (comb_q[j_q] ? rows_q : cols_q) * fsel;
	assign cost     = cds_pkg::COST_W'(pc_s1) + cds_pkg::COST_W'(pr_s1);

	assign ylt     = {{(LW-NW){1'b0}}, col_q} < ry_q;
	assign zlt     = {{(LW-NW){1'b0}}, row_q} < rz_q;
	assign ly_n    = ylt ? qy_q + 1'b1 : qy_q;
	assign lz_n    = zlt ? qz_q + 1'b1 : qz_q;
	assign my_full = col_q * ly_n;
	assign mz_full = row_q * lz_n;

	assign status.rank_bad  = rank_q >= cpu_count;
	assign status.fac_done  = n_q <= NW'(1);
	assign status.fac_stop  = (nf_q >= FCW'(MAX_FACTORS - 1))
		|| (32'(d_q) >= cds_pkg::MAX_PRIME) || (dd > {{NW{1'b0}}, n_q});
	assign status.comb_done = comb_q == (CBW'(1) << nf_q);
	assign status.mul_done  = j_q == nf_q;
	assign status.div_done  = div_done;

	always_ff @(posedge clk) begin
		case (cmd.op)
			cds_pkg::OP_LOAD: begin
				rank_q <= rank;
			end
			cds_pkg::OP_FAC_INIT: begin
				n_q  <= cpu_count;
				d_q  <= NW'(2);
				nf_q <= '0;
			end
			cds_pkg::OP_FAC_APPEND: begin
				fac_q[nf_q[JW-1:0]] <= n_q;
				nf_q <= nf_q + 1'b1;
			end
			cds_pkg::OP_FAC_WAIT: begin
				if (div_done) begin
					if (div_r == '0) begin
						fac_q[nf_q[JW-1:0]] <= d_q;
						nf_q <= nf_q + 1'b1;
						n_q  <= div_q[NW-1:0];
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
			end
			cds_pkg::OP_COMB_INIT: begin
				comb_q      <= '0;
				have_q      <= 1'b0;
				best_cols_q <= NW'(1);
				best_rows_q <= NW'(1);
			end
			cds_pkg::OP_COMB_START: begin
				cols_q <= NW'(1);
				rows_q <= NW'(1);
				j_q    <= '0;
			end
			cds_pkg::OP_COMB_MUL: begin
				if (comb_q[j_q]) rows_q <= fprod[NW-1:0];
				else cols_q <= fprod[NW-1:0];
				j_q <= j_q + 1'b1;
			end
			cds_pkg::OP_COST_MUL: begin
				pc_s1 <= cols_q * cells_z;
				pr_s1 <= rows_q * cells_y;
			end
			cds_pkg::OP_COST_CMP: begin
				if (!have_q || cost < best_cost_q) begin
					best_cost_q <= cost;
					best_cols_q <= cols_q;
					best_rows_q <= rows_q;
				end
				have_q <= 1'b1;
				comb_q <= comb_q + 1'b1;
			end
			cds_pkg::OP_RANK_WAIT: begin
				if (div_done) begin
					col_q <= div_r[NW-1:0];
					row_q <= div_q[NW-1:0];
				end
			end
			cds_pkg::OP_Y_WAIT: begin
				if (div_done) begin
					qy_q <= div_q;
					ry_q <= div_r;
				end
			end
			cds_pkg::OP_Z_WAIT: begin
				if (div_done) begin
					qz_q <= div_q;
					rz_q <= div_r;
				end
			end
			cds_pkg::OP_SHARE_MUL: begin
				ylt_q <= ylt;
				zlt_q <= zlt;
				ly_s1 <= ly_n;
				lz_s1 <= lz_n;
				my_s1 <= my_full[LW-1:0];
				mz_s1 <= mz_full[LW-1:0];
			end
			default: begin
			end
		endcase
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_error <= 1'b0;
		end else if (cmd.op == cds_pkg::OP_ERR) begin
			rank_error <= 1'b1;
		end else if (cmd.op == cds_pkg::OP_FINISH) begin
			rank_error <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == cds_pkg::OP_ERR) begin
			grid_cols      <= '0;
			grid_rows      <= '0;
			col_index      <= '0;
			row_index      <= '0;
			local_y_cells  <= '0;
			local_z_cells  <= '0;
			y_offset       <= '0;
			z_offset       <= '0;
			boundary_flags <= '0;
		end else if (cmd.op == cds_pkg::OP_FINISH) begin
			grid_cols      <= best_cols_q;
			grid_rows      <= best_rows_q;
			col_index      <= col_q;
			row_index      <= row_q;
			local_y_cells  <= ly_s1;
			local_z_cells  <= lz_s1;
			y_offset       <= my_s1 + (ylt_q ? '0 : ry_q);
			z_offset       <= mz_s1 + (zlt_q ? '0 : rz_q);
			boundary_flags[0] <= col_q == '0;
			boundary_flags[1] <= col_q == best_cols_q - 1'b1;
			boundary_flags[2] <= !periodic_z && (row_q == '0);
			boundary_flags[3] <= !periodic_z && (row_q == best_rows_q - 1'b1);
		end
	end

endmodule
`default_nettype wire

FILE: src/cds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer: factoring, combination search, rank placement, hand-off.
// ----------------------------------------------------------------------------
module cds_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output cds_pkg::dp_cmd_t          cmd,
	input  wire cds_pkg::dp_status_t  status
);
	cds_pkg::ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cds_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd.op    = cds_pkg::OP_NONE;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			cds_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = cds_pkg::OP_LOAD;
					state_n = cds_pkg::ST_CHECK;
				end
			end
			cds_pkg::ST_CHECK: begin
				if (status.rank_bad) begin
					cmd.op  = cds_pkg::OP_ERR;
					state_n = cds_pkg::ST_OUT;
				end else begin
					cmd.op  = cds_pkg::OP_FAC_INIT;
					state_n = cds_pkg::ST_FAC;
				end
			end
			cds_pkg::ST_FAC: begin
				if (status.fac_done) begin
					state_n = cds_pkg::ST_COMB_INIT;
				end else if (status.fac_stop) begin
					cmd.op  = cds_pkg::OP_FAC_APPEND;
					state_n = cds_pkg::ST_COMB_INIT;
				end else begin
					cmd.op  = cds_pkg::OP_FAC_DIV;
					state_n = cds_pkg::ST_FAC_WAIT;
				end
			end
			cds_pkg::ST_FAC_WAIT: begin
				cmd.op = cds_pkg::OP_FAC_WAIT;
				if (status.div_done) state_n = cds_pkg::ST_FAC;
			end
			cds_pkg::ST_COMB_INIT: begin
				cmd.op  = cds_pkg::OP_COMB_INIT;
				state_n = cds_pkg::ST_COMB_START;
			end
			cds_pkg::ST_COMB_START: begin
				if (status.comb_done) begin
					state_n = cds_pkg::ST_RANK_DIV;
				end else begin
					cmd.op  = cds_pkg::OP_COMB_START;
					state_n = cds_pkg::ST_COMB_MUL;
				end
			end
			cds_pkg::ST_COMB_MUL: begin
				if (status.mul_done) begin
					state_n = cds_pkg::ST_COST_MUL;
				end else begin
					cmd.op = cds_pkg::OP_COMB_MUL;
				end
			end
			cds_pkg::ST_COST_MUL: begin
				cmd.op  = cds_pkg::OP_COST_MUL;
				state_n = cds_pkg::ST_COST_CMP;
			end
			cds_pkg::ST_COST_CMP: begin
				cmd.op  = cds_pkg::OP_COST_CMP;
				state_n = cds_pkg::ST_COMB_START;
			end
			cds_pkg::ST_RANK_DIV: begin
				cmd.op  = cds_pkg::OP_RANK_DIV;
				state_n = cds_pkg::ST_RANK_WAIT;
			end
			cds_pkg::ST_RANK_WAIT: begin
				cmd.op = cds_pkg::OP_RANK_WAIT;
				if (status.div_done) state_n = cds_pkg::ST_Y_DIV;
			end
			cds_pkg::ST_Y_DIV: begin
				cmd.op  = cds_pkg::OP_Y_DIV;
				state_n = cds_pkg::ST_Y_WAIT;
			end
			cds_pkg::ST_Y_WAIT: begin
				cmd.op = cds_pkg::OP_Y_WAIT;
				if (status.div_done) state_n = cds_pkg::ST_Z_DIV;
			end
			cds_pkg::ST_Z_DIV: begin
				cmd.op  = cds_pkg::OP_Z_DIV;
				state_n = cds_pkg::ST_Z_WAIT;
			end
			cds_pkg::ST_Z_WAIT: begin
				cmd.op = cds_pkg::OP_Z_WAIT;
				if (status.div_done) state_n = cds_pkg::ST_SHARE_MUL;
			end
			cds_pkg::ST_SHARE_MUL: begin
				cmd.op  = cds_pkg::OP_SHARE_MUL;
				state_n = cds_pkg::ST_FINISH;
			end
			cds_pkg::ST_FINISH: begin
				cmd.op  = cds_pkg::OP_FINISH;
				state_n = cds_pkg::ST_OUT;
			end
			cds_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_n = cds_pkg::ST_IDLE;
			end
			default: begin
				state_n = cds_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: src/cartesian_domain_split.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_domain_split
// Splits the processor count into a 2-D grid of least surface cost and
// returns one rank's place, local cell counts, offsets and boundary flags.
// ----------------------------------------------------------------------------
// An out-of-range rank goes from the check straight to the result. Otherwise
//   the run is set by T, the trial divisions (at most 62 for a 12-bit count),
//   and nf, the prime factors (at most 11), as 2^nf combinations are tried.
// Each pass through the shared divider is an issue state and a wait for done;
// each combination walks its factors one per cycle, then its cost is compared.
// Throughput: one transaction at a time; a new rank is taken once the result
// has left. Reset clears the sequencer and loads the register defaults.
// ----------------------------------------------------------------------------
module cartesian_domain_split #(
	parameter int MAX_FACTORS = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [3:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	// request channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [cds_pkg::CNT_W-1:0]  rank,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [cds_pkg::CNT_W-1:0]       grid_cols,
	output logic [cds_pkg::CNT_W-1:0]       grid_rows,
	output logic [cds_pkg::CNT_W-1:0]       col_index,
	output logic [cds_pkg::CNT_W-1:0]       row_index,
	output logic [cds_pkg::CELL_W-1:0]      local_y_cells,
	output logic [cds_pkg::CELL_W-1:0]      local_z_cells,
	output logic [cds_pkg::CELL_W-1:0]      y_offset,
	output logic [cds_pkg::CELL_W-1:0]      z_offset,
	output logic [3:0]                      boundary_flags,
	output logic                            rank_error
);
	// Configuration registers: user writes only while no transaction is in flight.
	logic [cds_pkg::CNT_W-1:0]  cpu_count_q;
	logic [cds_pkg::CELL_W-1:0] cells_y_q;
	logic [cds_pkg::CELL_W-1:0] cells_z_q;
	logic                       periodic_z_q;
	logic                       wr_en;

	cds_pkg::dp_cmd_t    cmd;
	cds_pkg::dp_status_t status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_count_q  <= cds_pkg::CNT_W'(1);
			cells_y_q    <= cds_pkg::CELL_W'(1);
			cells_z_q    <= cds_pkg::CELL_W'(1);
			periodic_z_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				cds_pkg::REG_CPU_COUNT:  cpu_count_q  <= pwdata[cds_pkg::CNT_W-1:0];
				cds_pkg::REG_CELLS_Y:    cells_y_q    <= pwdata[cds_pkg::CELL_W-1:0];
				cds_pkg::REG_CELLS_Z:    cells_z_q    <= pwdata[cds_pkg::CELL_W-1:0];
				cds_pkg::REG_PERIODIC_Z: periodic_z_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Readback, zero-extended to the bus width.
	always_comb begin
		case (paddr[3:2])
			cds_pkg::REG_CPU_COUNT:  prdata = 32'(cpu_count_q);
			cds_pkg::REG_CELLS_Y:    prdata = 32'(cells_y_q);
			cds_pkg::REG_CELLS_Z:    prdata = 32'(cells_z_q);
			cds_pkg::REG_PERIODIC_Z: prdata = 32'(periodic_z_q);
			default:                 prdata = '0;
		endcase
	end

	// Sequencer: owns both handshakes and steps the datapath.
	cds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath: factor store, cost search, shared divider, result registers.
	cds_datapath #(
		.MAX_FACTORS (MAX_FACTORS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cpu_count      (cpu_count_q),
		.cells_y        (cells_y_q),
		.cells_z        (cells_z_q),
		.periodic_z     (periodic_z_q),
		.rank           (rank),
		.grid_cols      (grid_cols),
		.grid_rows      (grid_rows),
		.col_index      (col_index),
		.row_index      (row_index),
		.local_y_cells  (local_y_cells),
		.local_z_cells  (local_z_cells),
		.y_offset       (y_offset),
		.z_offset       (z_offset),
		.boundary_flags (boundary_flags),
		.rank_error     (rank_error)
	);

endmodule
`default_nettype wire
